>>> rtl/core/access_list_key_table_assert.svh
// Assertion macros shared by the access list key table RTL.
// Needs a clk and an active-high rst in the scope where a macro is used.
`ifndef ACCESS_LIST_KEY_TABLE_ASSERT_SVH
`define ACCESS_LIST_KEY_TABLE_ASSERT_SVH
`ifndef SYNTH
`define ALKT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ALKT_ASSERT_RAW(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ALKT_ASSERT(label, prop, msg)
`define ALKT_ASSERT_RAW(label, prop, msg)
`endif
`endif

>>> rtl/core/alkt_pkg.sv
// Shared types, codes and default sizes for the access list key table.
// Used by alkt_cell and access_list_key_table; depends on nothing.
package alkt_pkg;

  localparam int ENTRIES_DEF     = 32;
  localparam int RIGHT_COUNT_DEF = 4;
  localparam int KEY_BITS_DEF    = 64;

  localparam int OP_W     = 2;
  localparam int RIGHT_FW = 4;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_RIGHT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                vld;
    logic [OP_W-1:0]     op;
    logic [RIGHT_FW-1:0] right;
    logic                done;
    logic [STATUS_W-1:0] status;
  } token_t;

endpackage

>>> rtl/core/alkt_cell.sv
// One entry of the key table: stored key, right tag and valid mark, plus
// the request register that hands the request on to the next entry.
// Depends on alkt_pkg and access_list_key_table_assert.svh.
`include "access_list_key_table_assert.svh"

module alkt_cell #(
  parameter int KEY_BITS = alkt_pkg::KEY_BITS_DEF,
  parameter int RIGHT_W  = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  alkt_pkg::token_t    tok_in,
  input  logic [KEY_BITS-1:0] key_in,
  output alkt_pkg::token_t    tok_out,
  output logic [KEY_BITS-1:0] key_out
);

  logic                entry_valid;
  logic                entry_valid_next;
  logic [KEY_BITS-1:0] key_store;
  logic [RIGHT_W-1:0]  right_tag;
  logic                live;
  logic                hit;
  logic                claim_free;
  logic                claim_match;
  alkt_pkg::token_t    tok_next;

  always_comb begin
    live        = tok_in.vld && !tok_in.done;
    hit         = entry_valid && (key_store == key_in) &&
                  (right_tag == tok_in.right[RIGHT_W-1:0]);
    claim_free  = live && (tok_in.op == alkt_pkg::OP_APPEND) && !entry_valid;
    claim_match = live && hit &&
                  ((tok_in.op == alkt_pkg::OP_CHECK) || (tok_in.op == alkt_pkg::OP_DELETE));
    tok_next = tok_in;
    if (claim_free || claim_match) begin
      tok_next.done   = 1'b1;
      tok_next.status = alkt_pkg::ST_OK;
    end
    entry_valid_next = entry_valid;
    if (claim_free) begin
      entry_valid_next = 1'b1;
    end else if (claim_match && (tok_in.op == alkt_pkg::OP_DELETE)) begin
      entry_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      tok_out     <= '0;
    end else if (advance) begin
      entry_valid <= entry_valid_next;
      tok_out     <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_out <= key_in;
    end
    if (advance && claim_free) begin
      key_store <= key_in;
      right_tag <= tok_in.right[RIGHT_W-1:0];
    end
  end

  `ALKT_ASSERT(a_done_kept, advance && tok_in.vld && tok_in.done |=> tok_out.done, "resolved request lost its result")
  `ALKT_ASSERT(a_fill_by_append, !$past(rst) && $rose(entry_valid) |-> $past(advance && tok_in.vld && (tok_in.op == alkt_pkg::OP_APPEND)), "entry filled without an append")
  `ALKT_ASSERT(a_free_by_delete, !$past(rst) && $fell(entry_valid) |-> $past(advance && tok_in.vld && (tok_in.op == alkt_pkg::OP_DELETE)), "entry freed without a delete")

endmodule

>>> rtl/core/access_list_key_table.sv
// Access list key table: a store of ENTRIES keys, each tagged with a right.
// A request carries op (append, check, delete), auth_key and right_index and
// yields one status transfer: 0 ok or found, 1 not found, 2 bad right,
// 3 store full. Requests enter on in_valid/in_stall, results leave on
// out_valid/out_stall, one result per request and in request order.
// The store is a row of ENTRIES cells, one entry each; a request steps one
// cell per cycle unless the row holds; every cell sees requests in arrival
// order, and each request settles against the state its predecessors left.
// The status passes through the request registers of all ENTRIES cells.
// Throughput: one request per cycle while the output is taken.
// When out_stall is high with a result waiting, the whole row holds and
// in_stall is raised; the row moves again in the cycle the result goes.
// Reset empties the store and discards requests in flight. Only the low
// KEY_BITS bits of auth_key are stored and compared. Depends on alkt_pkg,
// alkt_cell and the assertion header.
`include "access_list_key_table_assert.svh"

module access_list_key_table #(
  parameter int ENTRIES     = alkt_pkg::ENTRIES_DEF,
  parameter int RIGHT_COUNT = alkt_pkg::RIGHT_COUNT_DEF,
  parameter int KEY_BITS    = alkt_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [alkt_pkg::OP_W-1:0]       op,
  input  logic [63:0]                     auth_key,
  input  logic [alkt_pkg::RIGHT_FW-1:0]   right_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [alkt_pkg::STATUS_W-1:0]   status
);

  localparam int RIGHT_W = (RIGHT_COUNT > 1) ? $clog2(RIGHT_COUNT) : 1;
  localparam logic [alkt_pkg::RIGHT_FW:0] RIGHT_LIM = (alkt_pkg::RIGHT_FW + 1)'(RIGHT_COUNT);

  alkt_pkg::token_t    tok  [0:ENTRIES];
  logic [KEY_BITS-1:0] keys [0:ENTRIES];
  alkt_pkg::token_t    tok_head;
  logic                advance;
  logic                bad_right;

  assign advance   = !tok[ENTRIES].vld || !out_stall;
  assign in_stall  = !advance;
  assign out_valid = tok[ENTRIES].vld;
  assign status    = tok[ENTRIES].status;
  assign tok[0]    = tok_head;
  assign keys[0]   = auth_key[KEY_BITS-1:0];

  always_comb begin
    bad_right      = {1'b0, right_index} >= RIGHT_LIM;
    tok_head.vld   = in_valid;
    tok_head.op    = op;
    tok_head.right = right_index;
    tok_head.done  = 1'b0;
    unique case (op)
      alkt_pkg::OP_APPEND: tok_head.status = alkt_pkg::ST_FULL;
      alkt_pkg::OP_CHECK,
      alkt_pkg::OP_DELETE: tok_head.status = alkt_pkg::ST_NOT_FOUND;
      default: begin
        tok_head.done   = 1'b1;
        tok_head.status = alkt_pkg::ST_NOT_FOUND;
      end
    endcase
    if (bad_right) begin
      tok_head.done   = 1'b1;
      tok_head.status = alkt_pkg::ST_BAD_RIGHT;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    alkt_cell #(
      .KEY_BITS (KEY_BITS),
      .RIGHT_W  (RIGHT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (tok[i]),
      .key_in  (keys[i]),
      .tok_out (tok[i+1]),
      .key_out (keys[i+1])
    );
  end

  `ALKT_ASSERT(a_done_at_exit, out_valid |-> tok[ENTRIES].done || (tok[ENTRIES].status != alkt_pkg::ST_OK), "unresolved request reported ok")
  `ALKT_ASSERT(a_full_only_append, out_valid && (status == alkt_pkg::ST_FULL) |-> (tok[ENTRIES].op == alkt_pkg::OP_APPEND), "store full reported for a non-append")
  `ALKT_ASSERT_RAW(a_reset_empties, rst |=> !out_valid, "result left after reset")

endmodule

>>> verif/access_list_key_table_tb.sv
// Self-checking testbench for access_list_key_table: drives append, check and delete requests,
// predicts each status from its own copy of the key store and compares every result transfer.
// Depends on alkt_pkg and the access_list_key_table RTL.
`timescale 1ns / 100ps

module access_list_key_table_tb;

  localparam int ENTRIES      = alkt_pkg::ENTRIES_DEF;
  localparam int RIGHT_COUNT  = alkt_pkg::RIGHT_COUNT_DEF;
  localparam int KEY_BITS     = alkt_pkg::KEY_BITS_DEF;
  localparam int RANDOM_ITEMS = 630;
  localparam int POOL_SIZE    = 6;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_LEN     = 120;
  localparam int QUIET_FROM   = 300;
  localparam int QUIET_TO     = 550;

  localparam logic [alkt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [63:0] KEY_MASK = (KEY_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                      : ((64'd1 << KEY_BITS) - 64'd1);

  typedef struct packed {
    logic [alkt_pkg::OP_W-1:0]     op;
    logic [63:0]                   key;
    logic [alkt_pkg::RIGHT_FW-1:0] right;
  } acl_req_t;

  typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_NOISE} burst_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [alkt_pkg::OP_W-1:0]     op = alkt_pkg::OP_CHECK;
  logic [63:0]                   auth_key = 64'd0;
  logic [alkt_pkg::RIGHT_FW-1:0] right_index = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [alkt_pkg::STATUS_W-1:0] status;

  acl_req_t                      req_pending [$];
  logic [alkt_pkg::STATUS_W-1:0] status_due [$];
  acl_req_t                      next_req;
  logic [alkt_pkg::STATUS_W-1:0] want_status;

  logic [63:0]                   acl_key [ENTRIES];
  logic [alkt_pkg::RIGHT_FW-1:0] acl_right [ENTRIES];
  bit                            acl_used [ENTRIES];

  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  int          mismatch_cnt = 0;
  logic        quiet;

  access_list_key_table #(
    .ENTRIES    (ENTRIES),
    .RIGHT_COUNT(RIGHT_COUNT),
    .KEY_BITS   (KEY_BITS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .auth_key   (auth_key),
    .right_index(right_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  assign quiet = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

  function automatic logic [alkt_pkg::STATUS_W-1:0] acl_apply(
      input logic [alkt_pkg::OP_W-1:0] req_op,
      input logic [63:0] req_key,
      input logic [alkt_pkg::RIGHT_FW-1:0] req_right);
    logic [63:0] k;
    int hit;
    int slot;
    k = req_key & KEY_MASK;
    hit = -1;
    slot = -1;
    if (req_right >= RIGHT_COUNT) return alkt_pkg::ST_BAD_RIGHT;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!acl_used[i]) slot = i;
      if (acl_used[i] && acl_key[i] == k && acl_right[i] == req_right) hit = i;
    end
    case (req_op)
      alkt_pkg::OP_APPEND: begin
        if (slot < 0) return alkt_pkg::ST_FULL;
        acl_key[slot] = k;
        acl_right[slot] = req_right;
        acl_used[slot] = 1'b1;
        return alkt_pkg::ST_OK;
      end
      alkt_pkg::OP_CHECK: return (hit >= 0) ? alkt_pkg::ST_OK : alkt_pkg::ST_NOT_FOUND;
      alkt_pkg::OP_DELETE: begin
        if (hit < 0) return alkt_pkg::ST_NOT_FOUND;
        acl_used[hit] = 1'b0;
        return alkt_pkg::ST_OK;
      end
      default: return alkt_pkg::ST_NOT_FOUND;
    endcase
  endfunction

  function automatic acl_req_t make_req(input logic [alkt_pkg::OP_W-1:0] req_op,
                                        input logic [63:0] req_key,
                                        input logic [alkt_pkg::RIGHT_FW-1:0] req_right);
    acl_req_t r;
    r.op = req_op;
    r.key = req_key;
    r.right = req_right;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [alkt_pkg::STATUS_W-1:0] got,
                                 input logic [alkt_pkg::STATUS_W-1:0] want);
    $display("%0t: %s, status %0d, expected %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        status_due.push_back(acl_apply(op, auth_key, right_index));
      end
      if (!in_valid || !in_stall) begin
        if (req_pending.size() != 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
          next_req = req_pending.pop_front();
          in_valid <= 1'b1;
          op <= next_req.op;
          auth_key <= next_req.key;
          right_index <= next_req.right;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (cycle_cnt == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 6);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        report_mismatch("result transfer with no request outstanding", status,
                        alkt_pkg::ST_OK);
      end else begin
        want_status = status_due.pop_front();
        if (status !== want_status) report_mismatch("wrong status", status, want_status);
      end
    end
  end

  initial begin
    logic [63:0]                   key_pool [POOL_SIZE];
    logic [63:0]                   ones;
    logic [alkt_pkg::OP_W-1:0]     r_op;
    logic [63:0]                   r_key;
    logic [alkt_pkg::RIGHT_FW-1:0] r_right;
    burst_mode_t                   mode;
    int                            made;
    int                            len;
    int                            pick;

    ones = 64'hFFFF_FFFF_FFFF_FFFF;
    for (int i = 0; i < ENTRIES; i++) acl_used[i] = 1'b0;

    // Directed part: empty store, key extremes, duplicates, bad rights and the unused op.
    req_pending.push_back(make_req(alkt_pkg::OP_DELETE, 64'd0, 4'd0));
    req_pending.push_back(make_req(alkt_pkg::OP_CHECK, 64'd0, 4'd0));
    req_pending.push_back(make_req(alkt_pkg::OP_APPEND, 64'd0, 4'd0));
    req_pending.push_back(make_req(alkt_pkg::OP_APPEND, ones, 4'd3));
    req_pending.push_back(make_req(alkt_pkg::OP_CHECK, 64'd0, 4'd0));
    req_pending.push_back(make_req(alkt_pkg::OP_CHECK, ones, 4'd3));
    req_pending.push_back(make_req(alkt_pkg::OP_CHECK, ones, 4'd0));
    req_pending.push_back(make_req(alkt_pkg::OP_CHECK, 64'd1, 4'd0));
    req_pending.push_back(make_req(alkt_pkg::OP_APPEND, 64'd0, 4'd0));
    req_pending.push_back(make_req(alkt_pkg::OP_DELETE, 64'd0, 4'd0));
    req_pending.push_back(make_req(alkt_pkg::OP_CHECK, 64'd0, 4'd0));
    req_pending.push_back(make_req(alkt_pkg::OP_DELETE, 64'd0, 4'd0));
    req_pending.push_back(make_req(alkt_pkg::OP_DELETE, 64'd0, 4'd0));
    req_pending.push_back(make_req(alkt_pkg::OP_APPEND, ones, 4'd4));
    req_pending.push_back(make_req(alkt_pkg::OP_CHECK, ones, 4'd15));
    req_pending.push_back(make_req(alkt_pkg::OP_DELETE, ones, 4'd4));
    req_pending.push_back(make_req(OP_UNUSED, ones, 4'd15));
    req_pending.push_back(make_req(OP_UNUSED, 64'd0, 4'd0));
    req_pending.push_back(make_req(OP_UNUSED, ones, 4'd3));
    req_pending.push_back(make_req(alkt_pkg::OP_DELETE, ones, 4'd3));
    req_pending.push_back(make_req(alkt_pkg::OP_CHECK, ones, 4'd3));

    key_pool[0] = 64'd0;
    key_pool[1] = ones;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    // Random part in bursts, so that the store is both filled to the top and drained.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode = (made == 0) ? MODE_FILL : burst_mode_t'($urandom_range(0, 3));
      len = $urandom_range(20, 60);
      for (int j = 0; j < len && made < RANDOM_ITEMS; j++) begin
        pick = $urandom_range(0, 99);
        case (mode)
          MODE_FILL:  r_op = (pick < 88) ? alkt_pkg::OP_APPEND :
                             ((pick < 95) ? alkt_pkg::OP_CHECK : alkt_pkg::OP_DELETE);
          MODE_DRAIN: r_op = (pick < 65) ? alkt_pkg::OP_DELETE :
                             ((pick < 90) ? alkt_pkg::OP_CHECK : alkt_pkg::OP_APPEND);
          MODE_MIX:   r_op = (pick < 35) ? alkt_pkg::OP_APPEND :
                             ((pick < 70) ? alkt_pkg::OP_CHECK : alkt_pkg::OP_DELETE);
          default:    r_op = alkt_pkg::OP_W'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 99) < ((mode == MODE_NOISE) ? 50 : 85)) begin
          r_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          r_key = {$urandom, $urandom};
        end
        if (mode == MODE_NOISE) begin
          r_right = alkt_pkg::RIGHT_FW'($urandom_range(0, 15));
        end else if ($urandom_range(0, 99) < 4) begin
          r_right = alkt_pkg::RIGHT_FW'($urandom_range(RIGHT_COUNT, 15));
        end else begin
          r_right = alkt_pkg::RIGHT_FW'($urandom_range(0, RIGHT_COUNT - 1));
        end
        req_pending.push_back(make_req(r_op, r_key, r_right));
        made++;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (req_pending.size() != 0 || in_valid || status_due.size() != 0) @(negedge clk);
    repeat (ENTRIES + 16) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/alkt_pkg.sv
rtl/core/alkt_cell.sv
rtl/core/access_list_key_table.sv
verif/access_list_key_table_tb.sv
